// ----- hdl/blv_pkg.sv -----
// ----------------------------------------------------------------------------
// blv_pkg
// Shared constants and types of the blocked local variance unit.
// ----------------------------------------------------------------------------
package blv_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_BLOCK  = 15;

  localparam int PIX_ROWS  = MAX_BLOCK + 1;
  localparam int MEAN_ROWS = MAX_BLOCK / 2 + 1;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int PROW_W  = $clog2(PIX_ROWS);
  localparam int MROW_W  = $clog2(MEAN_ROWS);
  localparam int PADDR_W = PROW_W + COL_W;
  localparam int MADDR_W = MROW_W + COL_W;
  localparam int DIM_W   = 11;
  localparam int BLK_W   = 4;
  localparam int HALF_W  = BLK_W - 1;
  localparam int BB_W    = 2 * BLK_W;
  localparam int SQ_W    = 32;
  localparam int ACC_W   = SQ_W + 1 + $clog2(MAX_BLOCK * MAX_BLOCK);
  localparam int STEP_W  = $clog2(ACC_W + 1);
  localparam int VAR_W   = 33;
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [BLK_W-1:0] BLOCK_RESET = 4'd3;
  localparam logic [DIM_W-1:0] WIDTH_MAX   = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_MAX  = DIM_W'(MAX_HEIGHT);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_MWAIT,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV
  } blv_state_t;

  typedef struct packed {
    logic               en;
    logic [PADDR_W-1:0] addr;
  } pix_rd_t;

  typedef struct packed {
    logic               en;
    logic [MADDR_W-1:0] addr;
  } mean_rd_t;

endpackage

// ----- hdl/blv_store.sv -----
// ----------------------------------------------------------------------------
// blv_store
// Pixel and mean line stores, one write and one registered read port each.
// ----------------------------------------------------------------------------
module blv_store (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [blv_pkg::PADDR_W-1:0]  pix_wr_addr,
  input  logic [31:0]                  pix_wr_data,
  input  logic [blv_pkg::MADDR_W-1:0]  mean_wr_addr,
  input  logic [31:0]                  mean_wr_data,
  input  blv_pkg::pix_rd_t             pix_rd,
  input  blv_pkg::mean_rd_t            mean_rd,
  output logic [31:0]                  pix_rd_data,
  output logic [31:0]                  mean_rd_data
);

  logic [31:0] pix_mem  [blv_pkg::PIX_ROWS * blv_pkg::MAX_WIDTH];
  logic [31:0] mean_mem [blv_pkg::MEAN_ROWS * blv_pkg::MAX_WIDTH];
  logic [31:0] pix_rd_r;
  logic [31:0] mean_rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pix_mem[pix_wr_addr] <= pix_wr_data;
    end
    if (pix_rd.en) begin
      pix_rd_r <= pix_mem[pix_rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mean_mem[mean_wr_addr] <= mean_wr_data;
    end
    if (mean_rd.en) begin
      mean_rd_r <= mean_mem[mean_rd.addr];
    end
  end

  assign pix_rd_data  = pix_rd_r;
  assign mean_rd_data = mean_rd_r;

endmodule

// ----- hdl/blv_div.sv -----
// ----------------------------------------------------------------------------
// blv_div
// Restoring divider, one quotient bit per cycle; result holds until restart.
// ----------------------------------------------------------------------------
module blv_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [blv_pkg::ACC_W-1:0]  dividend,
  input  logic [blv_pkg::BB_W-1:0]   divisor,
  output logic                       busy,
  output logic                       done,
  output logic [blv_pkg::ACC_W-1:0]  quotient
);

  logic [blv_pkg::ACC_W-1:0]  quo_r;
  logic [blv_pkg::BB_W-1:0]   rem_r;
  logic [blv_pkg::BB_W-1:0]   dsr_r;
  logic [blv_pkg::STEP_W-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [blv_pkg::BB_W:0]     trial;
  logic                       fits;

  assign trial = {rem_r, quo_r[blv_pkg::ACC_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == blv_pkg::STEP_W'(blv_pkg::ACC_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[blv_pkg::ACC_W-2:0], fits};
      rem_r <= fits ? blv_pkg::BB_W'(trial - {1'b0, dsr_r}) : trial[blv_pkg::BB_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- hdl/blocked_local_variance_unit.sv -----
// ----------------------------------------------------------------------------
// blocked_local_variance_unit
// Local variance of complex pixels over an odd B x B block around each
// interior centre, using line stores in block memory.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | pixel_real/imag, mean_real/imag
//   out     | output    | out_valid/out_stall| center_row/col, block_variance
//   cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A pixel that completes no block leaves the unit idle and ready for the next pixel.
// A pixel that completes a block stalls the input while the unit reads the mean,
// reads the B*B pixels through the single pixel store port, drains the
// square-and-add pipeline, runs the divider and loads the result.
// No clearing pass after reset; counters start at zero.
// A stalled result waits in the output register while the next pixel enters.
// ----------------------------------------------------------------------------
module blocked_local_variance_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [15:0]          in_pixel_real,
  input  logic signed [15:0]          in_pixel_imag,
  input  logic signed [15:0]          in_mean_real,
  input  logic signed [15:0]          in_mean_imag,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [9:0]                  out_center_row,
  output logic [9:0]                  out_center_col,
  output logic [32:0]                 out_block_variance,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [blv_pkg::IDX_W-1:0]   cfg_index,
  input  logic [blv_pkg::DIM_W-1:0]   cfg_data
);

  blv_pkg::blv_state_t state_r, state_nxt;

  logic [blv_pkg::BLK_W-1:0] blk_r;
  logic [blv_pkg::DIM_W-1:0] width_r;
  logic [blv_pkg::DIM_W-1:0] height_r;
  logic [blv_pkg::ROW_W-1:0] row_r;
  logic [blv_pkg::COL_W-1:0] col_r;

  logic [blv_pkg::DIM_W-1:0]  eff_w;
  logic [blv_pkg::DIM_W-1:0]  eff_h;
  logic [blv_pkg::HALF_W-1:0] half;
  logic [blv_pkg::BLK_W-1:0]  span;
  logic [blv_pkg::ROW_W-1:0]  cur_r;
  logic [blv_pkg::COL_W-1:0]  cur_c;
  logic [blv_pkg::DIM_W-1:0]  nxt_c;
  logic [blv_pkg::DIM_W-1:0]  nxt_r;
  logic                       in_acc;
  logic                       emit;

  logic [blv_pkg::ROW_W-1:0] crow_r;
  logic [blv_pkg::COL_W-1:0] ccol_r;
  logic [blv_pkg::ROW_W-1:0] r0_r;
  logic [blv_pkg::COL_W-1:0] c0_r;
  logic [blv_pkg::BLK_W-1:0] dy_r;
  logic [blv_pkg::BLK_W-1:0] dx_r;
  logic                      scan_last;
  logic [blv_pkg::ROW_W-1:0] scan_y;
  logic [blv_pkg::COL_W-1:0] scan_x;

  logic [31:0]                pix_q;
  logic [31:0]                mean_q;
  logic [31:0]                mean_r;
  logic                       v1_r;
  logic                       v2_r;
  logic signed [16:0]         dr;
  logic signed [16:0]         di;
  logic signed [33:0]         pr;
  logic signed [33:0]         pi;
  logic [blv_pkg::SQ_W-1:0]   sqr_r;
  logic [blv_pkg::SQ_W-1:0]   sqi_r;
  logic [blv_pkg::ACC_W-1:0]  acc_r;

  blv_pkg::pix_rd_t  pix_rd;
  blv_pkg::mean_rd_t mean_rd;

  logic                       div_start;
  logic                       div_busy;
  logic                       div_done;
  logic [blv_pkg::ACC_W-1:0]  div_q;
  logic [blv_pkg::BB_W-1:0]   bb;
  logic                       out_load;
  logic                       out_valid_r;
  logic [9:0]                 out_row_r;
  logic [9:0]                 out_col_r;
  logic [32:0]                out_var_r;

  assign eff_w = (width_r == '0) ? blv_pkg::DIM_W'(1) :
                 (width_r > blv_pkg::WIDTH_MAX) ? blv_pkg::WIDTH_MAX : width_r;
  assign eff_h = (height_r == '0) ? blv_pkg::DIM_W'(1) :
                 (height_r > blv_pkg::HEIGHT_MAX) ? blv_pkg::HEIGHT_MAX : height_r;
  assign half  = blk_r[blv_pkg::BLK_W-1:1];
  assign span  = blk_r - 1'b1;

  always_comb begin
    cur_r = row_r;
    cur_c = col_r;
    if ({1'b0, row_r} >= eff_h || {1'b0, col_r} >= eff_w) begin
      cur_r = '0;
      cur_c = '0;
    end
  end

  assign nxt_c  = {1'b0, cur_c} + 1'b1;
  assign nxt_r  = {1'b0, cur_r} + 1'b1;
  assign in_acc = in_valid && !in_stall;
  assign emit   = ({7'd0, blk_r} <= eff_w) && ({7'd0, blk_r} <= eff_h) &&
                  (cur_r >= blv_pkg::ROW_W'(span)) && (cur_c >= blv_pkg::COL_W'(span));

  assign scan_last = (dy_r == span) && (dx_r == span);
  assign scan_y    = r0_r + blv_pkg::ROW_W'(dy_r);
  assign scan_x    = c0_r + blv_pkg::COL_W'(dx_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      blv_pkg::ST_IDLE:  if (in_acc && emit) state_nxt = blv_pkg::ST_MEAN;
      blv_pkg::ST_MEAN:  state_nxt = blv_pkg::ST_MWAIT;
      blv_pkg::ST_MWAIT: state_nxt = blv_pkg::ST_SCAN;
      blv_pkg::ST_SCAN:  if (scan_last) state_nxt = blv_pkg::ST_DRAIN;
      blv_pkg::ST_DRAIN: if (!v1_r && !v2_r) state_nxt = blv_pkg::ST_DIV;
      blv_pkg::ST_DIV:   if (out_load) state_nxt = blv_pkg::ST_IDLE;
      default:           state_nxt = blv_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall     = 1'b1;
    cfg_ready    = 1'b0;
    pix_rd.en    = 1'b0;
    pix_rd.addr  = {scan_y[blv_pkg::PROW_W-1:0], scan_x};
    mean_rd.en   = 1'b0;
    mean_rd.addr = {crow_r[blv_pkg::MROW_W-1:0], ccol_r};
    div_start    = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      blv_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        cfg_ready = 1'b1;
      end
      blv_pkg::ST_MEAN:  mean_rd.en = 1'b1;
      blv_pkg::ST_SCAN:  pix_rd.en  = 1'b1;
      blv_pkg::ST_DRAIN: div_start  = !v1_r && !v2_r;
      blv_pkg::ST_DIV:   out_load   = div_done && !div_busy && (!out_valid_r || !out_stall);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= blv_pkg::ST_IDLE;
      blk_r    <= blv_pkg::BLOCK_RESET;
      width_r  <= blv_pkg::WIDTH_MAX;
      height_r <= blv_pkg::HEIGHT_MAX;
      row_r    <= '0;
      col_r    <= '0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= pix_rd.en;
      v2_r    <= v1_r;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          blv_pkg::REG_BLOCK_SIZE: begin
            if (cfg_data[0]) begin
              blk_r <= cfg_data[blv_pkg::BLK_W-1:0];
              row_r <= '0;
              col_r <= '0;
            end
          end
          blv_pkg::REG_IMAGE_WIDTH: begin
            width_r <= cfg_data;
            row_r   <= '0;
            col_r   <= '0;
          end
          blv_pkg::REG_IMAGE_HEIGHT: begin
            height_r <= cfg_data;
            row_r    <= '0;
            col_r    <= '0;
          end
          default: ;
        endcase
      end else if (in_acc) begin
        if (nxt_c >= eff_w) begin
          col_r <= '0;
          row_r <= (nxt_r >= eff_h) ? '0 : nxt_r[blv_pkg::ROW_W-1:0];
        end else begin
          col_r <= nxt_c[blv_pkg::COL_W-1:0];
          row_r <= cur_r;
        end
      end
    end
  end

  // block geometry and scan counters
  always_ff @(posedge clk) begin
    if (in_acc) begin
      crow_r <= cur_r - blv_pkg::ROW_W'(half);
      ccol_r <= cur_c - blv_pkg::COL_W'(half);
      r0_r   <= cur_r - blv_pkg::ROW_W'(span);
      c0_r   <= cur_c - blv_pkg::COL_W'(span);
    end
    if (state_r == blv_pkg::ST_MWAIT) begin
      mean_r <= mean_q;
      dy_r   <= '0;
      dx_r   <= '0;
    end else if (state_r == blv_pkg::ST_SCAN) begin
      if (dx_r == span) begin
        dx_r <= '0;
        dy_r <= dy_r + 1'b1;
      end else begin
        dx_r <= dx_r + 1'b1;
      end
    end
  end

  blv_store u_store (
    .clk          (clk),
    .wr_en        (in_acc),
    .pix_wr_addr  ({cur_r[blv_pkg::PROW_W-1:0], cur_c}),
    .pix_wr_data  ({in_pixel_imag, in_pixel_real}),
    .mean_wr_addr ({cur_r[blv_pkg::MROW_W-1:0], cur_c}),
    .mean_wr_data ({in_mean_imag, in_mean_real}),
    .pix_rd       (pix_rd),
    .mean_rd      (mean_rd),
    .pix_rd_data  (pix_q),
    .mean_rd_data (mean_q)
  );

  assign dr = $signed({pix_q[15], pix_q[15:0]}) - $signed({mean_r[15], mean_r[15:0]});
  assign di = $signed({pix_q[31], pix_q[31:16]}) - $signed({mean_r[31], mean_r[31:16]});
  assign pr = dr * dr;
  assign pi = di * di;

  always_ff @(posedge clk) begin
    sqr_r <= pr[blv_pkg::SQ_W-1:0];
    sqi_r <= pi[blv_pkg::SQ_W-1:0];
    if (state_r == blv_pkg::ST_MWAIT) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + blv_pkg::ACC_W'(sqr_r) + blv_pkg::ACC_W'(sqi_r);
    end
  end

  assign bb = {4'd0, blk_r} * {4'd0, blk_r};

  blv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .divisor  (bb),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r <= crow_r;
      out_col_r <= ccol_r;
      out_var_r <= div_q[32:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_center_row     = out_row_r;
  assign out_center_col     = out_col_r;
  assign out_block_variance = out_var_r;

  a_emit_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && emit |=> state_r == blv_pkg::ST_MEAN)
    else $error("block completion did not start a scan");

  a_drain_divides: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> div_busy)
    else $error("divider did not start");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> state_r == blv_pkg::ST_SCAN || state_r == blv_pkg::ST_DRAIN)
    else $error("accumulate outside scan");

  a_load_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && state_r == blv_pkg::ST_IDLE)
    else $error("result load lost");

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the blocked local variance unit. Streams complex pixels and
// means through a set of block sizes and image shapes and checks every
// result against a predictor that computes the block sums from line stores
// of its own. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYC = 300;
  localparam int HOLD_CYC   = 600;
  localparam int RND_ITEMS  = 500;
  localparam int RND_CHUNK  = 100;

  localparam logic [blv_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum {ROW_CFG, ROW_PIX} row_kind_t;
  typedef enum {RES_NONE, RES_PRED, RES_TYPED} row_res_t;

  typedef struct {
    row_kind_t                 kind;
    logic [blv_pkg::IDX_W-1:0] idx;
    logic [blv_pkg::DIM_W-1:0] data;
    logic [15:0]               pr, pi, mr, mi;
    int                        rep;
    row_res_t                  res;
    logic [32:0]               val;
  } stim_row_t;

  typedef struct packed {
    logic [9:0]  row;
    logic [9:0]  col;
    logic [32:0] variance;
  } variance_t;

  typedef struct {
    logic        typed;
    logic [32:0] val;
  } typed_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_pixel_real = '0, in_pixel_imag = '0;
  logic signed [15:0] in_mean_real = '0, in_mean_imag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [9:0] out_center_row, out_center_col;
  logic [32:0] out_block_variance;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [blv_pkg::IDX_W-1:0] cfg_index = '0;
  logic [blv_pkg::DIM_W-1:0] cfg_data = '0;

  always #1 clk = ~clk;

  blocked_local_variance_unit u_top (.*);

  // predictor state
  int unsigned blk_size, img_w, img_h, row_ctr, col_ctr;
  logic signed [15:0] pix_re [blv_pkg::PIX_ROWS*blv_pkg::MAX_WIDTH];
  logic signed [15:0] pix_im [blv_pkg::PIX_ROWS*blv_pkg::MAX_WIDTH];
  logic signed [15:0] mean_re [blv_pkg::MEAN_ROWS*blv_pkg::MAX_WIDTH];
  logic signed [15:0] mean_im [blv_pkg::MEAN_ROWS*blv_pkg::MAX_WIDTH];

  variance_t variance_q[$];
  typed_t    typed_q[$];
  stim_row_t stim_tab[$];

  int n_in, n_out, n_cfg, fails, idle_cyc, n_phase;
  bit quiet, hold_req;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned mx);
    if (v == 0) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  function automatic void apply_reg(logic [blv_pkg::IDX_W-1:0] idx,
                                    logic [blv_pkg::DIM_W-1:0] data);
    case (idx)
      blv_pkg::REG_BLOCK_SIZE: begin
        if (data[0] == 1'b0) return;
        blk_size = data[3:0];
      end
      blv_pkg::REG_IMAGE_WIDTH:  img_w = data;
      blv_pkg::REG_IMAGE_HEIGHT: img_h = data;
      default: return;
    endcase
    row_ctr = 0;
    col_ctr = 0;
  endfunction

  function automatic void predict_variance(logic signed [15:0] pr, pi, mr, mi);
    int unsigned w, ht, b, h, r, c, cr, cc, ma, pa;
    longint signed dr, di;
    longint unsigned sum;
    variance_t res;
    typed_t tv;
    w = clamp_dim(img_w, blv_pkg::MAX_WIDTH);
    ht = clamp_dim(img_h, blv_pkg::MAX_HEIGHT);
    b = blk_size;
    h = b / 2;
    r = row_ctr;
    c = col_ctr;
    if (r >= ht || c >= w) begin
      r = 0;
      c = 0;
    end
    pix_re[(r % blv_pkg::PIX_ROWS) * blv_pkg::MAX_WIDTH + c] = pr;
    pix_im[(r % blv_pkg::PIX_ROWS) * blv_pkg::MAX_WIDTH + c] = pi;
    mean_re[(r % blv_pkg::MEAN_ROWS) * blv_pkg::MAX_WIDTH + c] = mr;
    mean_im[(r % blv_pkg::MEAN_ROWS) * blv_pkg::MAX_WIDTH + c] = mi;
    if (b <= w && b <= ht && r >= 2 * h && c >= 2 * h) begin
      cr = r - h;
      cc = c - h;
      ma = (cr % blv_pkg::MEAN_ROWS) * blv_pkg::MAX_WIDTH + cc;
      sum = 0;
      for (int unsigned y = r - 2 * h; y <= r; y++)
        for (int unsigned x = c - 2 * h; x <= c; x++) begin
          pa = (y % blv_pkg::PIX_ROWS) * blv_pkg::MAX_WIDTH + x;
          dr = longint'(pix_re[pa]) - longint'(mean_re[ma]);
          di = longint'(pix_im[pa]) - longint'(mean_im[ma]);
          sum += longint'(dr * dr + di * di);
        end
      res.row = cr[9:0];
      res.col = cc[9:0];
      res.variance = 33'(sum / longint'(b * b));
      variance_q.push_back(res);
      if (typed_q.size() != 0) begin
        tv = typed_q.pop_front();
        if (tv.typed && tv.val !== res.variance) begin
          $error("block_variance (table): expected %0d, actual %0d", tv.val, res.variance);
          fails++;
        end
      end
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= ht) r = 0;
    end
    row_ctr = r;
    col_ctr = c;
  endfunction

  always @(posedge clk) begin
    variance_t e;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        n_cfg++;
      end
      if (in_valid && !in_stall) begin
        predict_variance(in_pixel_real, in_pixel_imag, in_mean_real, in_mean_imag);
        n_in++;
      end
      if (out_valid && !out_stall) begin
        n_out++;
        if (variance_q.size() == 0) begin
          $error("unexpected result at row %0d col %0d", out_center_row, out_center_col);
          fails++;
        end else begin
          e = variance_q.pop_front();
          if (out_center_row !== e.row) begin
            $error("center_row: expected %0d, actual %0d", e.row, out_center_row);
            fails++;
          end
          if (out_center_col !== e.col) begin
            $error("center_col: expected %0d, actual %0d", e.col, out_center_col);
            fails++;
          end
          if (out_block_variance !== e.variance) begin
            $error("block_variance: expected %0d, actual %0d", e.variance,
                   out_block_variance);
            fails++;
          end
        end
      end
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) ||
          (out_valid && !out_stall)) idle_cyc = 0;
      else idle_cyc++;
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result side stalls
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYC) @(negedge clk);
        hold_req = 1'b0;
        out_stall = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_pixel(logic [15:0] pr, pi, mr, mi);
    int cnt;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_pixel_real = pr;
    in_pixel_imag = pi;
    in_mean_real = mr;
    in_mean_imag = mi;
    cnt = n_in;
    do @(negedge clk); while (n_in == cnt);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (variance_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_reg(logic [blv_pkg::IDX_W-1:0] idx, logic [blv_pkg::DIM_W-1:0] data);
    int cnt;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    cnt = n_cfg;
    do @(negedge clk); while (n_cfg == cnt);
    cfg_valid = 1'b0;
  endtask

  task automatic stream_random(int n);
    for (int k = 0; k < n; k++)
      send_pixel($urandom, $urandom, $urandom, $urandom);
    in_valid = 1'b0;
  endtask

  function automatic void add_cfg(logic [blv_pkg::IDX_W-1:0] idx,
                                  logic [blv_pkg::DIM_W-1:0] data);
    stim_row_t s;
    s = '{kind: ROW_CFG, idx: idx, data: data, pr: 0, pi: 0, mr: 0, mi: 0,
          rep: 1, res: RES_NONE, val: 0};
    stim_tab.push_back(s);
  endfunction

  function automatic void add_pix(logic [15:0] pr, pi, mr, mi, int rep, row_res_t res,
                                  logic [32:0] val);
    stim_row_t s;
    s = '{kind: ROW_PIX, idx: 0, data: 0, pr: pr, pi: pi, mr: mr, mi: mi,
          rep: rep, res: res, val: val};
    stim_tab.push_back(s);
  endfunction

  initial begin
    int rnd_items, b, w, h, n;
    stim_row_t s;
    typed_t tv;
    blk_size = blv_pkg::BLOCK_RESET;
    img_w = blv_pkg::MAX_WIDTH;
    img_h = blv_pkg::MAX_HEIGHT;
    row_ctr = 0;
    col_ctr = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    add_cfg(blv_pkg::REG_IMAGE_WIDTH, 11'd1);
    add_cfg(blv_pkg::REG_IMAGE_HEIGHT, 11'd1);
    add_cfg(blv_pkg::REG_BLOCK_SIZE, 11'd1);
    add_pix(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 1, RES_TYPED, 33'd8589672450);
    add_pix(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 1, RES_TYPED, 33'd8589672450);
    add_pix(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, RES_TYPED, 33'd0);
    add_pix(16'h0001, 16'h0000, 16'h0000, 16'h0000, 1, RES_TYPED, 33'd1);
    add_pix(16'hffff, 16'hffff, 16'h0000, 16'h0000, 1, RES_TYPED, 33'd2);
    add_cfg(blv_pkg::REG_BLOCK_SIZE, 11'd2);
    add_pix(16'h0005, 16'h0000, 16'h0002, 16'h0000, 1, RES_TYPED, 33'd9);
    add_cfg(blv_pkg::REG_BLOCK_SIZE, 11'd0);
    add_cfg(REG_UNUSED, 11'h7ff);
    add_cfg(blv_pkg::REG_IMAGE_WIDTH, 11'd3);
    add_cfg(blv_pkg::REG_IMAGE_HEIGHT, 11'd3);
    add_cfg(blv_pkg::REG_BLOCK_SIZE, 11'd3);
    add_pix(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 8, RES_NONE, 0);
    add_pix(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 1, RES_TYPED, 33'd8589672450);
    add_cfg(blv_pkg::REG_IMAGE_WIDTH, 11'd2);
    add_pix(16'h0007, 16'h0007, 16'h0000, 16'h0000, 6, RES_NONE, 0);
    add_cfg(blv_pkg::REG_IMAGE_WIDTH, 11'd0);
    add_cfg(blv_pkg::REG_BLOCK_SIZE, 11'd1);
    add_pix(16'h0003, 16'h0004, 16'h0000, 16'h0000, 3, RES_TYPED, 33'd25);
    add_cfg(blv_pkg::REG_IMAGE_WIDTH, 11'h7ff);
    add_cfg(blv_pkg::REG_IMAGE_HEIGHT, 11'h7ff);
    add_pix(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 2, RES_TYPED, 33'd8589672450);
    add_cfg(blv_pkg::REG_BLOCK_SIZE, 11'h7f5);
    add_pix(16'h1234, 16'hedcb, 16'h0100, 16'hff00, 4, RES_PRED, 0);

    foreach (stim_tab[i]) begin
      s = stim_tab[i];
      if (s.kind == ROW_CFG) begin
        settle();
        write_reg(s.idx, s.data);
      end else begin
        for (int k = 0; k < s.rep; k++) begin
          if (s.res != RES_NONE) begin
            tv.typed = (s.res == RES_TYPED);
            tv.val = s.val;
            typed_q.push_back(tv);
          end
          send_pixel(s.pr, s.pi, s.mr, s.mi);
        end
      end
    end
    settle();
    typed_q.delete();

    // last column, with a long receiver hold-off
    write_reg(blv_pkg::REG_IMAGE_HEIGHT, 11'd1);
    write_reg(blv_pkg::REG_IMAGE_WIDTH, 11'h7ff);
    write_reg(blv_pkg::REG_BLOCK_SIZE, 11'd1);
    hold_req = 1'b1;
    stream_random(blv_pkg::MAX_WIDTH);
    settle();

    rnd_items = 0;
    while (rnd_items < RND_ITEMS) begin
      b = 2 * $urandom_range(0, 7) + 1;
      w = $urandom_range(b, b + 6);
      h = $urandom_range(b, b + 6);
      case ($urandom_range(0, 9))
        0: w = (b > 1) ? $urandom_range(1, b - 1) : 0;
        1: h = (b > 1) ? $urandom_range(1, b - 1) : 0;
        default: ;
      endcase
      if (rnd_items > RND_ITEMS - 150) quiet = 1'b1;
      settle();
      write_reg(blv_pkg::REG_IMAGE_WIDTH, w);
      write_reg(blv_pkg::REG_IMAGE_HEIGHT, h);
      write_reg(blv_pkg::REG_BLOCK_SIZE, {$urandom_range(0, 127), b[3:0]});
      case ($urandom_range(0, 5))
        0: write_reg(blv_pkg::REG_BLOCK_SIZE, {$urandom_range(0, 127), 3'($urandom), 1'b0});
        1: write_reg(REG_UNUSED, $urandom);
        default: ;
      endcase
      n = clamp_dim(w, blv_pkg::MAX_WIDTH) * clamp_dim(h, blv_pkg::MAX_HEIGHT);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : n * $urandom_range(1, 2);
      if (n > RND_CHUNK) n = RND_CHUNK;
      stream_random(n);
      rnd_items += n;
      n_phase++;
    end
    settle();

    $display("covered %0d pixels, %0d results, %0d register writes, %0d random shapes",
             n_in, n_out, n_cfg, n_phase);
    if (fails == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
